### hw/rtl/mono_page_framebuffer_window_writer_macros.svh
// Assertion macros used by the window writer's top-level RTL file.
`ifndef MONO_PAGE_FRAMEBUFFER_WINDOW_WRITER_MACROS_SVH
`define MONO_PAGE_FRAMEBUFFER_WINDOW_WRITER_MACROS_SVH

// The antecedent must be followed by the consequent in the same cycle.
`define MPFW_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The antecedent must be followed by the consequent in the next cycle.
`define MPFW_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/mpfw_pkg.sv
// Package with the window writer's codes, panel command bytes and shared types.
`timescale 1ns / 1ps
package mpfw_pkg;

   localparam int COLUMNS_DEFAULT = 128;
   localparam int ROWS_DEFAULT    = 64;

   localparam logic [2:0] ACT_SET_WINDOW = 3'd0;
   localparam logic [2:0] ACT_PIXEL      = 3'd1;
   localparam logic [2:0] ACT_READ       = 3'd2;
   localparam logic [2:0] ACT_CLEAR      = 3'd3;
   localparam logic [2:0] ACT_CONTRAST   = 3'd4;
   localparam logic [2:0] ACT_ORIENT     = 3'd5;

   localparam logic KIND_CMD  = 1'b0;
   localparam logic KIND_BYTE = 1'b1;

   localparam logic [15:0] WHITE_MASK     = 16'h8410;
   localparam logic [7:0]  CMD_PAGE       = 8'hB0;
   localparam logic [7:0]  CMD_COL_HI     = 8'h10;
   localparam logic [7:0]  COL_HI_MASK    = 8'h70;
   localparam logic [7:0]  NIBBLE_MASK    = 8'h0F;
   localparam logic [7:0]  CMD_CONTRAST   = 8'h81;
   localparam logic [7:0]  CMD_SEG_NORMAL = 8'hA1;
   localparam logic [7:0]  CMD_COM_NORMAL = 8'hC8;
   localparam logic [7:0]  CMD_SEG_FLIP   = 8'hA0;
   localparam logic [7:0]  CMD_COM_FLIP   = 8'hC0;

   localparam logic [8:0] CONTRAST_UNKNOWN = 9'd256;
   localparam logic [1:0] ORIENT_UNKNOWN   = 2'd0;
   localparam logic [1:0] ORIENT_NORMAL    = 2'd1;
   localparam logic [1:0] ORIENT_FLIP      = 2'd2;

   typedef struct packed {
      logic accept;
      logic exec;
      logic emit;
      logic clear;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] exec_count;
      logic       exec_clear;
      logic [1:0] remain;
      logic       clear_last;
   } dp_status_type;

   function automatic logic [7:0] cmd_page(input logic [7:0] page);
      return CMD_PAGE | (page & NIBBLE_MASK);
   endfunction

   function automatic logic [7:0] cmd_col_hi(input logic [7:0] col);
      return CMD_COL_HI | ((col & COL_HI_MASK) >> 4);
   endfunction

   function automatic logic [7:0] cmd_col_lo(input logic [7:0] col);
      return col & NIBBLE_MASK;
   endfunction

endpackage

### hw/rtl/mpfw_ctrl.sv
// Controller state machine of the window writer.
`timescale 1ns / 1ps
module mpfw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_strobe,
   output mpfw_pkg::ctl_cmd_type  cmd,
   input  mpfw_pkg::dp_status_type status
);
   import mpfw_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;
   localparam logic [1:0] ST_CLEAR = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.exec_clear)         state_in = ST_CLEAR;
            else if (status.exec_count != 2'd0) state_in = ST_EMIT;
            else                           state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (status.remain == 2'd1) state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The store is swept clean after reset before the first item is taken.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_EMIT);
   assign cmd.accept = start && (state_ff == ST_IDLE);
   assign cmd.exec   = (state_ff == ST_EXEC);
   assign cmd.emit   = (state_ff == ST_EMIT);
   assign cmd.clear  = (state_ff == ST_CLEAR);

endmodule

### hw/rtl/mpfw_dp.sv
// Datapath of the window writer: frame store, cursor, window and result buffer.
`timescale 1ns / 1ps
module mpfw_dp #(
   parameter int COLUMNS = mpfw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = mpfw_pkg::ROWS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mpfw_pkg::ctl_cmd_type   cmd,
   output mpfw_pkg::dp_status_type status,
   input  logic [2:0]              req_action,
   input  logic [7:0]              req_x_start,
   input  logic [7:0]              req_y_start,
   input  logic [7:0]              req_x_end,
   input  logic [7:0]              req_y_end,
   input  logic [15:0]             req_colour,
   input  logic [2:0]              req_read_page,
   input  logic [6:0]              req_read_column,
   input  logic [7:0]              req_contrast,
   input  logic                    req_flipped,
   output logic                    rsp_kind,
   output logic [7:0]              rsp_value,
   output logic                    rsp_last
);
   import mpfw_pkg::*;

   localparam int PAGES  = (ROWS + 7) / 8;
   localparam int DEPTH  = PAGES * COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam logic [8:0] COLS9  = 9'(COLUMNS);
   localparam logic [8:0] ROWS9  = 9'(ROWS);
   localparam logic [8:0] PAGES9 = 9'(PAGES);

   logic [7:0] mem [DEPTH];

   // Latched item.
   logic [2:0]  act_ff;
   logic [7:0]  xs_ff, ys_ff, xe_ff, ye_ff;
   logic        white_ff;
   logic        read_ok_ff;
   logic [7:0]  contrast_ff;
   logic        flipped_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [7:0]  rd_data_ff;

   // Cursor, window and panel shadow state.
   logic [COL_W-1:0] cur_col_ff, cur_col_in;
   logic [ROW_W-1:0] cur_row_ff, cur_row_in;
   logic [COL_W-1:0] win_left_ff, win_left_in, win_right_ff, win_right_in;
   logic [ROW_W-1:0] win_top_ff, win_top_in, win_bottom_ff, win_bottom_in;
   logic [8:0]       contrast_last_ff, contrast_last_in;
   logic [1:0]       orient_last_ff, orient_last_in;

   // Result buffer, shifted out one beat per cycle.
   logic            res_kind_ff, res_kind_in;
   logic [7:0]      res_value_ff [3];
   logic [7:0]      res_value_in [3];
   logic [1:0]      remain_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]  rd_page8;
   logic [7:0]  rd_col8;
   logic        rd_ok;
   logic [COL_W:0] col_inc;
   logic [ROW_W:0] row_inc;
   logic        col_wrap;
   logic        row_wrap;
   logic [7:0]  xe_clamp, ye_clamp;
   logic        win_ok;
   logic [1:0]  ex_count;
   logic        ex_clear;
   logic        ex_position;
   logic [7:0]  pos_row8, pos_col8;
   logic [7:0]  bit_mask;
   logic [7:0]  wr_byte;
   logic [1:0]  want_orient;

   // Read address: the requested byte for a read, the cursor byte otherwise.
   always_comb begin
      if (req_action == ACT_READ) begin
         rd_page8 = 8'(req_read_page);
         rd_col8  = 8'(req_read_column);
      end else begin
         rd_page8 = 8'(cur_row_ff) >> 3;
         rd_col8  = 8'(cur_col_ff);
      end
      rd_ok   = ({1'b0, rd_page8} < PAGES9) && ({1'b0, rd_col8} < COLS9);
      rd_addr = ADDR_W'(int'(rd_page8) * COLUMNS + int'(rd_col8));
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff      <= req_action;
         xs_ff       <= req_x_start;
         ys_ff       <= req_y_start;
         xe_ff       <= req_x_end;
         ye_ff       <= req_y_end;
         white_ff    <= ((req_colour & WHITE_MASK) != 16'd0);
         read_ok_ff  <= rd_ok;
         contrast_ff <= req_contrast;
         flipped_ff  <= req_flipped;
         addr_ff     <= rd_addr;
      end
   end

   assign bit_mask = 8'd1 << cur_row_ff[2:0];
   assign wr_byte  = white_ff ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask);

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clr_addr_ff] <= 8'd0;
      end else if (cmd.exec && act_ff == ACT_PIXEL) begin
         mem[addr_ff] <= wr_byte;
      end
      if (cmd.accept) rd_data_ff <= mem[rd_addr];
   end

   assign col_inc  = {1'b0, cur_col_ff} + (COL_W + 1)'(1);
   assign row_inc  = {1'b0, cur_row_ff} + (ROW_W + 1)'(1);
   assign col_wrap = col_inc > {1'b0, win_right_ff};
   assign row_wrap = row_inc > {1'b0, win_bottom_ff};
   assign xe_clamp = ({1'b0, xe_ff} >= COLS9) ? 8'(COLS9 - 9'd1) : xe_ff;
   assign ye_clamp = ({1'b0, ye_ff} >= ROWS9) ? 8'(ROWS9 - 9'd1) : ye_ff;
   assign win_ok   = ({1'b0, xs_ff} < COLS9) && (xs_ff <= xe_clamp)
                  && ({1'b0, ys_ff} < ROWS9) && (ys_ff <= ye_clamp);
   assign want_orient = flipped_ff ? ORIENT_FLIP : ORIENT_NORMAL;

   always_comb begin
      cur_col_in       = cur_col_ff;
      cur_row_in       = cur_row_ff;
      win_left_in      = win_left_ff;
      win_right_in     = win_right_ff;
      win_top_in       = win_top_ff;
      win_bottom_in    = win_bottom_ff;
      contrast_last_in = contrast_last_ff;
      orient_last_in   = orient_last_ff;
      ex_count         = 2'd0;
      ex_clear         = 1'b0;
      ex_position      = 1'b0;
      res_kind_in      = KIND_CMD;
      res_value_in[0]  = 8'd0;
      res_value_in[1]  = 8'd0;
      res_value_in[2]  = 8'd0;
      case (act_ff)
         ACT_SET_WINDOW: begin
            if (win_ok) begin
               win_left_in   = COL_W'(xs_ff);
               win_right_in  = COL_W'(xe_clamp);
               win_top_in    = ROW_W'(ys_ff);
               win_bottom_in = ROW_W'(ye_clamp);
               cur_col_in    = COL_W'(xs_ff);
               cur_row_in    = ROW_W'(ys_ff);
               ex_position   = 1'b1;
            end
         end
         ACT_PIXEL: begin
            if (col_wrap) begin
               cur_col_in  = win_left_ff;
               cur_row_in  = row_wrap ? win_top_ff : ROW_W'(row_inc);
               ex_position = 1'b1;
            end else begin
               cur_col_in = COL_W'(col_inc);
            end
         end
         ACT_READ: begin
            ex_count        = 2'd1;
            res_kind_in     = KIND_BYTE;
            res_value_in[0] = read_ok_ff ? rd_data_ff : 8'd0;
         end
         ACT_CLEAR: begin
            ex_clear      = 1'b1;
            win_left_in   = '0;
            win_right_in  = COL_W'(COLUMNS - 1);
            win_top_in    = '0;
            win_bottom_in = ROW_W'(ROWS - 1);
            cur_col_in    = '0;
            cur_row_in    = '0;
         end
         ACT_CONTRAST: begin
            if ({1'b0, contrast_ff} != contrast_last_ff) begin
               contrast_last_in = {1'b0, contrast_ff};
               ex_count         = 2'd2;
               res_value_in[0]  = CMD_CONTRAST;
               res_value_in[1]  = contrast_ff;
            end
         end
         ACT_ORIENT: begin
            if (want_orient != orient_last_ff) begin
               orient_last_in  = want_orient;
               ex_count        = 2'd2;
               res_value_in[0] = flipped_ff ? CMD_SEG_FLIP : CMD_SEG_NORMAL;
               res_value_in[1] = flipped_ff ? CMD_COM_FLIP : CMD_COM_NORMAL;
            end
         end
         default: begin
            ex_count = 2'd0;
         end
      endcase
      // Position commands always report the cursor as it stands after the item.
      pos_row8 = 8'(cur_row_in);
      pos_col8 = 8'(cur_col_in);
      if (ex_position) begin
         ex_count        = 2'd3;
         res_value_in[0] = cmd_page(pos_row8 >> 3);
         res_value_in[1] = cmd_col_hi(pos_col8);
         res_value_in[2] = cmd_col_lo(pos_col8);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff       <= '0;
         cur_row_ff       <= '0;
         win_left_ff      <= '0;
         win_right_ff     <= COL_W'(COLUMNS - 1);
         win_top_ff       <= '0;
         win_bottom_ff    <= ROW_W'(ROWS - 1);
         contrast_last_ff <= CONTRAST_UNKNOWN;
         orient_last_ff   <= ORIENT_UNKNOWN;
      end else if (cmd.exec) begin
         cur_col_ff       <= cur_col_in;
         cur_row_ff       <= cur_row_in;
         win_left_ff      <= win_left_in;
         win_right_ff     <= win_right_in;
         win_top_ff       <= win_top_in;
         win_bottom_ff    <= win_bottom_in;
         contrast_last_ff <= contrast_last_in;
         orient_last_ff   <= orient_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff   <= 2'd0;
         clr_addr_ff <= '0;
      end else begin
         if (cmd.exec) remain_ff <= ex_count;
         else if (cmd.emit) remain_ff <= remain_ff - 2'd1;
         if (cmd.exec && ex_clear) clr_addr_ff <= '0;
         else if (cmd.clear) clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_kind_ff     <= res_kind_in;
         res_value_ff[0] <= res_value_in[0];
         res_value_ff[1] <= res_value_in[1];
         res_value_ff[2] <= res_value_in[2];
      end else if (cmd.emit) begin
         res_value_ff[0] <= res_value_ff[1];
         res_value_ff[1] <= res_value_ff[2];
      end
   end

   assign status.exec_count = ex_count;
   assign status.exec_clear = ex_clear;
   assign status.remain     = remain_ff;
   assign status.clear_last = (clr_addr_ff == ADDR_W'(DEPTH - 1));

   assign rsp_kind  = res_kind_ff;
   assign rsp_value = res_value_ff[0];
   assign rsp_last  = (remain_ff == 2'd1);

endmodule

### hw/rtl/mono_page_framebuffer_window_writer.sv
// Top level of the monochrome page-addressed framebuffer window writer.
`timescale 1ns / 1ps
`include "mono_page_framebuffer_window_writer_macros.svh"
// An item is taken at a rising edge with start high and busy low; req_action picks
// set window, pixel, read byte, clear, contrast or orientation, the other req_ fields
// carry its operands. Results leave one beat per cycle on rsp_kind, rsp_value and
// rsp_last, marked by rsp_strobe; rsp_last flags the final beat of an item's run.
// Timing: the item is latched and the store byte under the cursor (or the requested
// byte) is read at the accept edge; the next cycle executes the item, including the
// read-modify-write of the pixel byte. An item's results, up to three beats, follow
// its execute state. A new item is taken only once the previous one is done, so the
// single-port-write frame store takes a new pixel only after the last is written.
// Clear sweeps the store one byte a cycle, PAGES * COLUMNS bytes (1024 by default),
// with busy high after its execute state until the sweep ends.
// Reset runs the same sweep, so busy stays high after reset is released until the
// sweep ends; the window returns to the full panel and the contrast and orientation
// shadows become unknown, so the next such item always sends its commands.
// The receiver cannot stall: every beat is presented for exactly one cycle.
module mono_page_framebuffer_window_writer #(
   parameter int COLUMNS = mpfw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = mpfw_pkg::ROWS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_x_start,
   input  logic [7:0]  req_y_start,
   input  logic [7:0]  req_x_end,
   input  logic [7:0]  req_y_end,
   input  logic [15:0] req_colour,
   input  logic [2:0]  req_read_page,
   input  logic [6:0]  req_read_column,
   input  logic [7:0]  req_contrast,
   input  logic        req_flipped,
   output logic        rsp_strobe,
   output logic        rsp_kind,
   output logic [7:0]  rsp_value,
   output logic        rsp_last
);
   import mpfw_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   mpfw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   mpfw_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_action      (req_action),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_colour      (req_colour),
      .req_read_page   (req_read_page),
      .req_read_column (req_read_column),
      .req_contrast    (req_contrast),
      .req_flipped     (req_flipped),
      .rsp_kind        (rsp_kind),
      .rsp_value       (rsp_value),
      .rsp_last        (rsp_last)
   );

   `MPFW_ASSERT_SAME(a_strobe_busy, rsp_strobe, busy, "result beat while not busy")
   `MPFW_ASSERT_NEXT(a_run_ends, rsp_strobe && rsp_last, !rsp_strobe, "beat after last")
   `MPFW_ASSERT_NEXT(a_run_contig, rsp_strobe && !rsp_last, rsp_strobe, "run broke early")
   `MPFW_ASSERT_SAME(a_byte_single, rsp_strobe && rsp_kind == KIND_BYTE, rsp_last,
                     "read-back beat is not the only beat")

endmodule
